/* design/amrs_pkg.sv */
// Shared types and constants of the adaptive mean-reversion signal unit.
`default_nettype none

package amrs_pkg;

    localparam int WINDOW_DEPTH_DEF  = 64;
    localparam int PENDING_LIMIT_DEF = 100;

    localparam int PRICE_W    = 32;
    localparam int TIME_W     = 64;
    localparam int OQTY_W     = 18;
    localparam int WL_W       = 7;
    localparam int THR_W      = 20;
    localparam int QTY_W      = 24;
    localparam int VOL_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_THRESHOLD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_QUANTITY   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_VOLATILITY  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_VOLATILITY = 3'd4;

    localparam logic [WL_W-1:0]  WINDOW_LENGTH_RST   = 7'd20;
    localparam logic [THR_W-1:0] BASE_THRESHOLD_RST  = 20'd256;
    localparam logic [QTY_W-1:0] BASE_QUANTITY_RST   = 24'd2560;
    localparam logic [VOL_W-1:0] LOW_VOLATILITY_RST  = 16'd1280;
    localparam logic [VOL_W-1:0] HIGH_VOLATILITY_RST = 16'd3840;

    // Return: percent with 8 fraction bits, magnitude saturated to 21 bits.
    localparam int RMAG_W = 21;
    localparam int RET_W  = RMAG_W + 1;
    localparam logic [RMAG_W-1:0] RET_LIMIT = 21'd2097151;
    localparam int RET_SCALE = 25600;

    localparam logic [THR_W-1:0] EPS_MIN = 20'd26;
    localparam logic [THR_W-1:0] EPS_MAX = 20'd25600;
    localparam logic [QTY_W-1:0] QTY_MIN = 24'd256;
    localparam logic [QTY_W-1:0] QTY_MAX = 24'd256000;

    // Reciprocals for exact floor division by 10 (inputs below 2^26)
    // and by 5 (inputs below 2^30).
    localparam logic [25:0] RECIP10  = 26'd53687092;
    localparam int          RECIP10_SH = 29;
    localparam logic [27:0] RECIP5   = 28'd214748365;
    localparam int          RECIP5_SH  = 30;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EV_RD,
        ST_EV_DROP,
        ST_EV_NEXT,
        ST_PREV_RD,
        ST_PREV_DATA,
        ST_DIV,
        ST_RET,
        ST_SQ,
        ST_PUSH,
        ST_SIG_MUL,
        ST_SIG_CMP,
        ST_AD_MUL0,
        ST_AD_MUL1,
        ST_AD_CMP,
        ST_AD_SCALE,
        ST_AD_MUL2,
        ST_AD_SET,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* design/amrs_channels.sv */
// Valid/ready channel interfaces for book updates and orders.
`default_nettype none

interface amrs_book_if;
    logic                         valid;
    logic                         ready;
    logic                         book_valid;
    logic [amrs_pkg::PRICE_W-1:0] bid_price;
    logic [amrs_pkg::PRICE_W-1:0] ask_price;
    logic [amrs_pkg::TIME_W-1:0]  update_time;
    logic                         pending_cleared;

    modport source (output valid, book_valid, bid_price, ask_price, update_time,
                    pending_cleared, input ready);
    modport sink (input valid, book_valid, bid_price, ask_price, update_time,
                  pending_cleared, output ready);
endinterface

interface amrs_order_if;
    logic                         valid;
    logic                         ready;
    logic                         order_valid;
    logic                         order_side;
    logic [amrs_pkg::PRICE_W-1:0] order_price;
    logic [amrs_pkg::OQTY_W-1:0]  order_quantity;
    logic [amrs_pkg::TIME_W-1:0]  order_time;

    modport source (output valid, order_valid, order_side, order_price, order_quantity,
                    order_time, input ready);
    modport sink (input valid, order_valid, order_side, order_price, order_quantity,
                  order_time, output ready);
endinterface

`default_nettype wire

/* design/adaptive_mean_reversion_signal_unit.sv */
// Adaptive mean-reversion signal unit: one sequenced datapath with an iterative divider.
//
// Channels: book (sink) takes one top-of-book update per transfer; order
// (source) gives exactly one result per update, order_valid = 0 when no
// order is created. Configuration is a plain write port (cfg_write, cfg_index,
// cfg_data); the user must write it only while idle, and the unit does not enforce it.
// Sequencing: an update with book_valid = 0 goes from idle straight to the
// finish state. A valid update runs through the window, signal and adaptation
// states, plus the restoring divider when a percentage return is formed (a
// nonzero previous midpoint exists). book.ready is high only in the idle state.
// The result sits in an output register; the unit returns to idle and takes
// the next update while that result waits. If the receiver still stalls when
// the next result is done, the sequencer holds until the register frees.
// Reset: registers return to their documented defaults, the window is empty,
// no pending orders are counted. The window rings need no clearing pass.
`default_nettype none

module adaptive_mean_reversion_signal_unit #(
    parameter int WINDOW_DEPTH  = amrs_pkg::WINDOW_DEPTH_DEF,
    parameter int PENDING_LIMIT = amrs_pkg::PENDING_LIMIT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    amrs_book_if.sink                              book,
    amrs_order_if.source                           order,
    input  wire logic                              cfg_write,
    input  wire logic [amrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [amrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import amrs_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int PW   = $clog2(PENDING_LIMIT + 1);
    localparam int MW   = PRICE_W + 1;
    localparam int WTW  = MW + CW;
    localparam int RTW  = RET_W + CW;
    localparam int SQW  = 2 * RMAG_W + CW;
    localparam int NUMW = SQW + CW;
    localparam int DENW = 2 * CW;
    localparam int HVDW = 2 * VOL_W + DENW;
    localparam int XW   = CW + THR_W;
    localparam int DVW  = MW + 15;
    localparam int DCW  = $clog2(DVW);
    localparam int RRW  = RET_W + 1;

    // Configuration
    logic [WL_W-1:0]  wl_reg;
    logic [THR_W-1:0] bt_reg;
    logic [QTY_W-1:0] bq_reg;
    logic [VOL_W-1:0] lv_reg;
    logic [VOL_W-1:0] hv_reg;

    // Window state
    logic [AW-1:0]           head_reg;
    logic [CW-1:0]           fill_reg;
    logic [CW-1:0]           cnt_reg;
    logic [WTW-1:0]          wt_reg;
    logic signed [RTW-1:0]   rt_reg;
    logic [SQW-1:0]          sq_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [QTY_W-1:0]        qty_reg;
    logic [PW-1:0]           pend_reg;

    state_t state_reg, state_next;

    // Item and work registers
    logic [PRICE_W-1:0] bid_reg;
    logic [PRICE_W-1:0] ask_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [MW-1:0]      s_reg;
    logic [AW-1:0]      old_reg;
    logic               neg_reg;
    logic [MW-1:0]      div_reg;
    logic [MW-1:0]      rem_reg;
    logic [DVW-1:0]     dvd_reg;
    logic [DCW-1:0]     dcnt_reg;
    logic [2*RMAG_W-1:0] term_reg;
    logic [WTW-1:0]     sn_reg;
    logic [XW-1:0]      x_reg;
    logic [NUMW-1:0]    p1_reg;
    logic [NUMW-1:0]    s2_reg;
    logic [DENW-1:0]    den_reg;
    logic [2*VOL_W-1:0] hv2_reg;
    logic [2*VOL_W-1:0] lv2_reg;
    logic [NUMW-1:0]    num_reg;
    logic [HVDW-1:0]    hvd_reg;
    logic [HVDW-1:0]    lvd_reg;
    logic               hi_reg;
    logic               lo_reg;
    logic [24:0]        tn_reg;
    logic [26:0]        qn_reg;
    logic [50:0]        tp_reg;
    logic [54:0]        qp_reg;

    // Result of the current item and the output register
    logic               res_valid_reg;
    logic               res_side_reg;
    logic [PRICE_W-1:0] res_price_reg;
    logic [OQTY_W-1:0]  res_qty_reg;
    logic               out_valid_reg;
    logic               out_ov_reg;
    logic               out_side_reg;
    logic [PRICE_W-1:0] out_price_reg;
    logic [OQTY_W-1:0]  out_qty_reg;
    logic [TIME_W-1:0]  out_time_reg;

    // Window rings
    logic [MW-1:0]  mid_mem [WINDOW_DEPTH];
    logic [RRW-1:0] ret_mem [WINDOW_DEPTH];
    logic           mid_we;
    logic [AW-1:0]  mid_waddr;
    logic [AW-1:0]  mid_raddr;
    logic [MW-1:0]  mid_rdata_reg;
    logic           ret_we;
    logic [AW-1:0]  ret_waddr;
    logic [RRW-1:0] ret_wdata;
    logic [AW-1:0]  ret_raddr;
    logic [RRW-1:0] ret_rdata_reg;
    logic           out_load;

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == AW'(WINDOW_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(WINDOW_DEPTH - 1) : a - AW'(1);
    endfunction

    // Effective window length
    logic [CW-1:0] len;
    always_comb
    begin
        if (wl_reg == '0)
            len = CW'(1);
        else if (int'(wl_reg) > WINDOW_DEPTH)
            len = CW'(WINDOW_DEPTH);
        else
            len = CW'(wl_reg);
    end

    // Oldest slot of the window
    logic [CW:0] head_x;
    logic [CW:0] fill_x;
    logic [CW:0] old_x;
    always_comb
    begin
        head_x = (CW+1)'(head_reg);
        fill_x = (CW+1)'(fill_reg);
        if (head_x >= fill_x)
            old_x = head_x - fill_x;
        else
            old_x = head_x + (CW+1)'(WINDOW_DEPTH) - fill_x;
    end

    // Return read back from the ring
    logic                  drop_ok;
    logic signed [RET_W-1:0] drop_r;
    logic [RMAG_W-1:0]     drop_mag;
    logic [2*RMAG_W-1:0]   drop_sq;
    assign drop_ok  = ret_rdata_reg[RET_W];
    assign drop_r   = signed'(ret_rdata_reg[RET_W-1:0]);
    assign drop_mag = drop_r[RET_W-1] ? RMAG_W'(-drop_r) : RMAG_W'(drop_r);
    assign drop_sq  = (2*RMAG_W)'(drop_mag) * (2*RMAG_W)'(drop_mag);

    // Divider step
    logic [MW:0] rem_sh;
    logic [MW:0] rem_sub;
    logic        qbit;
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[DVW-1]};
        rem_sub = rem_sh - {1'b0, div_reg};
        qbit    = rem_sh >= {1'b0, div_reg};
    end

    // New return from the quotient
    logic [RMAG_W-1:0]       new_mag;
    logic signed [RET_W-1:0] new_r;
    always_comb
    begin
        if (dvd_reg > DVW'(RET_LIMIT))
            new_mag = RET_LIMIT;
        else
            new_mag = dvd_reg[RMAG_W-1:0];
        new_r = neg_reg ? -signed'(RET_W'(new_mag)) : signed'(RET_W'(new_mag));
    end

    // Previous-midpoint operands
    logic          pneg;
    logic [MW-1:0] pdiff;
    always_comb
    begin
        pneg  = s_reg < mid_rdata_reg;
        pdiff = pneg ? mid_rdata_reg - s_reg : s_reg - mid_rdata_reg;
    end

    logic [RTW-2:0] rt_mag;
    assign rt_mag = rt_reg[RTW-1] ? (RTW-1)'(-rt_reg) : (RTW-1)'(rt_reg);

    // Clamped scaled values
    logic [THR_W-1:0] thr_scaled;
    logic [QTY_W-1:0] qty_scaled;
    logic [25:0]      tq;
    logic [25:0]      qq;
    always_comb
    begin
        tq = 26'(tp_reg >> RECIP10_SH);
        qq = hi_reg ? 26'(qp_reg >> RECIP5_SH) : {1'b0, bq_reg, 1'b0};
        if (tq < 26'(EPS_MIN))
            thr_scaled = EPS_MIN;
        else if (tq > 26'(EPS_MAX))
            thr_scaled = EPS_MAX;
        else
            thr_scaled = THR_W'(tq);
        if (qq < 26'(QTY_MIN))
            qty_scaled = QTY_MIN;
        else if (qq > 26'(QTY_MAX))
            qty_scaled = QTY_MAX;
        else
            qty_scaled = QTY_W'(qq);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        book.ready = 1'b0;
        mid_we     = 1'b0;
        mid_waddr  = head_reg;
        mid_raddr  = old_reg;
        ret_we     = 1'b0;
        ret_waddr  = head_reg;
        ret_wdata  = '0;
        ret_raddr  = old_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                book.ready = 1'b1;
                if (book.valid)
                begin
                    if (!book.book_valid)
                        state_next = ST_FINISH;
                    else if (fill_reg >= len)
                        state_next = ST_EV_RD;
                    else
                        state_next = ST_PREV_RD;
                end
            end
            ST_EV_RD:
                state_next = ST_EV_DROP;
            ST_EV_DROP:
            begin
                ret_raddr  = addr_inc(old_reg);
                state_next = (fill_reg >= CW'(2)) ? ST_EV_NEXT : ST_PREV_RD;
            end
            ST_EV_NEXT:
            begin
                // Mark the dropped return as gone
                ret_we     = 1'b1;
                ret_waddr  = addr_inc(old_reg);
                state_next = ST_PREV_RD;
            end
            ST_PREV_RD:
            begin
                mid_we    = 1'b1;
                mid_raddr = addr_dec(head_reg);
                if (fill_reg == '0)
                begin
                    ret_we     = 1'b1;
                    state_next = ST_PUSH;
                end
                else
                    state_next = ST_PREV_DATA;
            end
            ST_PREV_DATA:
            begin
                if (mid_rdata_reg == '0)
                begin
                    ret_we     = 1'b1;
                    state_next = ST_PUSH;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
                if (dcnt_reg == DCW'(DVW - 1))
                    state_next = ST_RET;
            ST_RET:
            begin
                ret_we     = 1'b1;
                ret_wdata  = {1'b1, new_r};
                state_next = ST_SQ;
            end
            ST_SQ:
                state_next = ST_PUSH;
            ST_PUSH:
                state_next = ST_SIG_MUL;
            ST_SIG_MUL:
                if (fill_reg >= CW'(2) && pend_reg < PW'(PENDING_LIMIT))
                    state_next = ST_SIG_CMP;
                else
                    state_next = ST_AD_MUL0;
            ST_SIG_CMP:
                state_next = ST_AD_MUL0;
            ST_AD_MUL0:
                if (fill_reg < CW'(3))
                    state_next = ST_FINISH;
                else if (cnt_reg < CW'(2))
                    state_next = ST_AD_SCALE;
                else
                    state_next = ST_AD_MUL1;
            ST_AD_MUL1:
                state_next = ST_AD_CMP;
            ST_AD_CMP:
                state_next = ST_AD_SCALE;
            ST_AD_SCALE:
                state_next = (hi_reg || lo_reg) ? ST_AD_MUL2 : ST_FINISH;
            ST_AD_MUL2:
                state_next = ST_AD_SET;
            ST_AD_SET:
                state_next = ST_FINISH;
            ST_FINISH:
                if (!out_valid_reg || order.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Rings: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (mid_we)
            mid_mem[mid_waddr] <= s_reg;
        mid_rdata_reg <= mid_mem[mid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ret_we)
            ret_mem[ret_waddr] <= ret_wdata;
        ret_rdata_reg <= ret_mem[ret_raddr];
    end

    // Datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg        <= WINDOW_LENGTH_RST;
            bt_reg        <= BASE_THRESHOLD_RST;
            bq_reg        <= BASE_QUANTITY_RST;
            lv_reg        <= LOW_VOLATILITY_RST;
            hv_reg        <= HIGH_VOLATILITY_RST;
            head_reg      <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            wt_reg        <= '0;
            rt_reg        <= '0;
            sq_reg        <= '0;
            thr_reg       <= BASE_THRESHOLD_RST;
            qty_reg       <= BASE_QUANTITY_RST;
            pend_reg      <= '0;
            bid_reg       <= '0;
            ask_reg       <= '0;
            time_reg      <= '0;
            s_reg         <= '0;
            old_reg       <= '0;
            neg_reg       <= 1'b0;
            div_reg       <= '0;
            rem_reg       <= '0;
            dvd_reg       <= '0;
            dcnt_reg      <= '0;
            term_reg      <= '0;
            sn_reg        <= '0;
            x_reg         <= '0;
            p1_reg        <= '0;
            s2_reg        <= '0;
            den_reg       <= '0;
            hv2_reg       <= '0;
            lv2_reg       <= '0;
            num_reg       <= '0;
            hvd_reg       <= '0;
            lvd_reg       <= '0;
            hi_reg        <= 1'b0;
            lo_reg        <= 1'b0;
            tn_reg        <= '0;
            qn_reg        <= '0;
            tp_reg        <= '0;
            qp_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_side_reg  <= 1'b0;
            res_price_reg <= '0;
            res_qty_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_ov_reg    <= 1'b0;
            out_side_reg  <= 1'b0;
            out_price_reg <= '0;
            out_qty_reg   <= '0;
            out_time_reg  <= '0;
        end
        else
        begin
            // Drop the transferred result unless a new one replaces it
            if (out_valid_reg && order.ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                    if (book.valid)
                    begin
                        bid_reg       <= book.bid_price;
                        ask_reg       <= book.ask_price;
                        time_reg      <= book.update_time;
                        s_reg         <= {1'b0, book.bid_price} + {1'b0, book.ask_price};
                        old_reg       <= old_x[AW-1:0];
                        res_valid_reg <= 1'b0;
                        res_side_reg  <= 1'b0;
                        res_price_reg <= '0;
                        res_qty_reg   <= '0;
                        if (book.pending_cleared)
                            pend_reg <= '0;
                    end
                ST_EV_RD:
                    ;
                ST_EV_DROP:
                begin
                    wt_reg   <= wt_reg - WTW'(mid_rdata_reg);
                    fill_reg <= fill_reg - CW'(1);
                    if (drop_ok)
                    begin
                        rt_reg  <= rt_reg - RTW'(drop_r);
                        sq_reg  <= sq_reg - SQW'(drop_sq);
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                ST_EV_NEXT:
                    if (drop_ok)
                    begin
                        rt_reg  <= rt_reg - RTW'(drop_r);
                        sq_reg  <= sq_reg - SQW'(drop_sq);
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                ST_PREV_RD:
                    ;
                ST_PREV_DATA:
                begin
                    neg_reg  <= pneg;
                    div_reg  <= mid_rdata_reg;
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    dvd_reg  <= DVW'(pdiff) * DVW'(RET_SCALE) + DVW'(mid_rdata_reg >> 1);
                end
                ST_DIV:
                begin
                    rem_reg  <= qbit ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
                    dvd_reg  <= {dvd_reg[DVW-2:0], qbit};
                    dcnt_reg <= dcnt_reg + DCW'(1);
                end
                ST_RET:
                begin
                    rt_reg   <= rt_reg + RTW'(new_r);
                    cnt_reg  <= cnt_reg + CW'(1);
                    term_reg <= (2*RMAG_W)'(new_mag) * (2*RMAG_W)'(new_mag);
                end
                ST_SQ:
                    sq_reg <= sq_reg + SQW'(term_reg);
                ST_PUSH:
                begin
                    wt_reg   <= wt_reg + WTW'(s_reg);
                    fill_reg <= fill_reg + CW'(1);
                    head_reg <= addr_inc(head_reg);
                end
                ST_SIG_MUL:
                begin
                    sn_reg <= WTW'(s_reg) * WTW'(fill_reg);
                    x_reg  <= (XW'(fill_reg) * XW'(thr_reg)) >> 7;
                end
                ST_SIG_CMP:
                begin
                    if (wt_reg > sn_reg && (wt_reg - sn_reg) > WTW'(x_reg))
                    begin
                        res_valid_reg <= 1'b1;
                        res_side_reg  <= 1'b0;
                        res_price_reg <= bid_reg;
                        res_qty_reg   <= (qty_reg > QTY_MAX) ? OQTY_W'(QTY_MAX)
                                                             : OQTY_W'(qty_reg);
                        pend_reg      <= pend_reg + PW'(1);
                    end
                    else if (sn_reg > wt_reg && (sn_reg - wt_reg) > WTW'(x_reg))
                    begin
                        res_valid_reg <= 1'b1;
                        res_side_reg  <= 1'b1;
                        res_price_reg <= ask_reg;
                        res_qty_reg   <= (qty_reg > QTY_MAX) ? OQTY_W'(QTY_MAX)
                                                             : OQTY_W'(qty_reg);
                        pend_reg      <= pend_reg + PW'(1);
                    end
                end
                ST_AD_MUL0:
                begin
                    hi_reg  <= 1'b0;
                    lo_reg  <= lv_reg != '0;
                    p1_reg  <= NUMW'(cnt_reg) * NUMW'(sq_reg);
                    s2_reg  <= NUMW'(rt_mag) * NUMW'(rt_mag);
                    den_reg <= DENW'(cnt_reg) * DENW'(cnt_reg - CW'(1));
                    hv2_reg <= (2*VOL_W)'(hv_reg) * (2*VOL_W)'(hv_reg);
                    lv2_reg <= (2*VOL_W)'(lv_reg) * (2*VOL_W)'(lv_reg);
                end
                ST_AD_MUL1:
                begin
                    num_reg <= p1_reg - s2_reg;
                    hvd_reg <= HVDW'(hv2_reg) * HVDW'(den_reg);
                    lvd_reg <= HVDW'(lv2_reg) * HVDW'(den_reg);
                end
                ST_AD_CMP:
                begin
                    hi_reg <= num_reg > NUMW'(hvd_reg);
                    lo_reg <= num_reg < NUMW'(lvd_reg);
                end
                ST_AD_SCALE:
                begin
                    if (hi_reg)
                    begin
                        tn_reg <= 25'(bt_reg) * 25'd17 + 25'd5;
                        qn_reg <= 27'((29'(bq_reg) * 29'd17 + 29'd10) >> 2);
                    end
                    else
                    begin
                        tn_reg <= 25'(bt_reg) * 25'd4 + 25'd5;
                        qn_reg <= '0;
                    end
                    if (!hi_reg && !lo_reg)
                    begin
                        thr_reg <= bt_reg;
                        qty_reg <= bq_reg;
                    end
                end
                ST_AD_MUL2:
                begin
                    tp_reg <= 51'(tn_reg) * 51'(RECIP10);
                    qp_reg <= 55'(qn_reg) * 55'(RECIP5);
                end
                ST_AD_SET:
                begin
                    thr_reg <= thr_scaled;
                    qty_reg <= qty_scaled;
                end
                ST_FINISH:
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ov_reg    <= res_valid_reg;
                        out_side_reg  <= res_side_reg;
                        out_price_reg <= res_price_reg;
                        out_qty_reg   <= res_qty_reg;
                        out_time_reg  <= res_valid_reg ? time_reg : '0;
                    end
                default:
                    ;
            endcase

            // Configuration writes must arrive only while idle; the unit does not enforce this.
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_WINDOW_LENGTH:
                    begin
                        wl_reg   <= WL_W'(cfg_data);
                        fill_reg <= '0;
                        cnt_reg  <= '0;
                        wt_reg   <= '0;
                        rt_reg   <= '0;
                        sq_reg   <= '0;
                    end
                    REG_BASE_THRESHOLD:
                    begin
                        bt_reg  <= THR_W'(cfg_data);
                        thr_reg <= THR_W'(cfg_data);
                    end
                    REG_BASE_QUANTITY:
                    begin
                        bq_reg  <= QTY_W'(cfg_data);
                        qty_reg <= QTY_W'(cfg_data);
                    end
                    REG_LOW_VOLATILITY:
                        lv_reg <= VOL_W'(cfg_data);
                    REG_HIGH_VOLATILITY:
                        hv_reg <= VOL_W'(cfg_data);
                    default:
                        ;
                endcase
            end
        end
    end

    assign order.valid          = out_valid_reg;
    assign order.order_valid    = out_ov_reg;
    assign order.order_side     = out_side_reg;
    assign order.order_price    = out_price_reg;
    assign order.order_quantity = out_qty_reg;
    assign order.order_time     = out_time_reg;

endmodule

`default_nettype wire
